// ===== src/iesf_pkg.sv =====
// ----------------------------------------------------------------------------
// iesf_pkg
// shared types and constants for the inverse error sensor fusion smoother
// ----------------------------------------------------------------------------
package iesf_pkg;

	// apb register file
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int EPS_W   = 16;
	localparam int CFG_W   = 17;

	// fixed point widths
	localparam int WGT_W   = 25;  // weight, at most 2^24
	localparam int SUMW_W  = 27;  // sum of three weights
	localparam int GAIN_W  = 17;  // q1.16 gain, at most one
	localparam int VAR_W   = 17;  // q1.16 variance

	localparam logic [GAIN_W-1:0] ONE_Q16    = 17'h10000;
	localparam logic [WGT_W-1:0]  WEIGHT_NUM = 25'h1000000;

	// register reset values
	localparam logic [EPS_W-1:0] RST_EPSILON    = 16'd256;
	localparam logic [CFG_W-1:0] RST_VAR_THRESH = 17'd32768;
	localparam logic [CFG_W-1:0] RST_GAIN_HIGH  = 17'd43691;
	localparam logic [CFG_W-1:0] RST_GAIN_LOW   = 17'd65536;
	localparam logic [VAR_W-1:0] RST_VARIANCE   = 17'h10000;

	typedef enum logic [1:0] {
		REG_EPSILON,
		REG_VAR_THRESH,
		REG_GAIN_HIGH,
		REG_GAIN_LOW
	} reg_idx_t;

	typedef struct packed {
		logic [EPS_W-1:0] epsilon;
		logic [CFG_W-1:0] var_thresh;
		logic [CFG_W-1:0] gain_high;
		logic [CFG_W-1:0] gain_low;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       err;
		logic       wstart;
		logic       wmul;
		logic       wacc;
		logic       fstart;
		logic       fzero;
		logic       fsign;
		logic       sgain;
		logic       smul;
		logic       supd;
		logic       oload;
		logic [1:0] idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fuse_en;
		logic sel_ok;
		logic div_done;
		logic sumw_zero;
	} sts_t;

endpackage

// ===== src/iesf_regs.sv =====
// ----------------------------------------------------------------------------
// iesf_regs
// apb configuration registers: epsilon, variance threshold and the two gains
// ----------------------------------------------------------------------------
module iesf_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [iesf_pkg::PADDR_W-1:0] paddr,
	input  logic [iesf_pkg::PDATA_W-1:0] pwdata,
	output logic [iesf_pkg::PDATA_W-1:0] prdata,
	output iesf_pkg::cfg_t               cfg
);

	iesf_pkg::cfg_t     cfg_q;
	iesf_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx   = iesf_pkg::reg_idx_t'(paddr[iesf_pkg::PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.epsilon    <= iesf_pkg::RST_EPSILON;
			cfg_q.var_thresh <= iesf_pkg::RST_VAR_THRESH;
			cfg_q.gain_high  <= iesf_pkg::RST_GAIN_HIGH;
			cfg_q.gain_low   <= iesf_pkg::RST_GAIN_LOW;
		end else if (wr_en) begin
			unique case (idx)
				iesf_pkg::REG_EPSILON:    cfg_q.epsilon    <= pwdata[iesf_pkg::EPS_W-1:0];
				iesf_pkg::REG_VAR_THRESH: cfg_q.var_thresh <= pwdata[iesf_pkg::CFG_W-1:0];
				iesf_pkg::REG_GAIN_HIGH:  cfg_q.gain_high  <= pwdata[iesf_pkg::CFG_W-1:0];
				iesf_pkg::REG_GAIN_LOW:   cfg_q.gain_low   <= pwdata[iesf_pkg::CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			iesf_pkg::REG_EPSILON:
				prdata = {{(iesf_pkg::PDATA_W-iesf_pkg::EPS_W){1'b0}}, cfg_q.epsilon};
			iesf_pkg::REG_VAR_THRESH:
				prdata = {{(iesf_pkg::PDATA_W-iesf_pkg::CFG_W){1'b0}}, cfg_q.var_thresh};
			iesf_pkg::REG_GAIN_HIGH:
				prdata = {{(iesf_pkg::PDATA_W-iesf_pkg::CFG_W){1'b0}}, cfg_q.gain_high};
			iesf_pkg::REG_GAIN_LOW:
				prdata = {{(iesf_pkg::PDATA_W-iesf_pkg::CFG_W){1'b0}}, cfg_q.gain_low};
		endcase
	end

endmodule

// ===== src/iesf_div.sv =====
// ----------------------------------------------------------------------------
// iesf_div
// restoring unsigned divider, one quotient bit per cycle, shared by the
// weight and the fused mean divisions
// ----------------------------------------------------------------------------
module iesf_div #(
	parameter int DEN_W = 34,
	parameter int QUO_W = 32,
	localparam int CNT_W = $clog2(QUO_W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] steps,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [QUO_W-1:0] quo_init,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   sub;
	logic             ge;

	// shift in the next numerator bit and try the subtract
	assign shifted = {rem_q, quo_q[QUO_W-1]};
	assign sub     = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= quo_init;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? sub[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== src/iesf_dp.sv =====
// ----------------------------------------------------------------------------
// iesf_dp
// datapath: input capture, weight and mean division, weighted sums and the
// gain-switched smoother state
// ----------------------------------------------------------------------------
module iesf_dp #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iesf_pkg::cmd_t                cmd,
	output iesf_pkg::sts_t                sts,
	input  iesf_pkg::cfg_t                cfg,
	input  logic signed [ANGLE_WIDTH-1:0] sensor_a_value,
	input  logic signed [ANGLE_WIDTH-1:0] sensor_b_value,
	input  logic signed [ANGLE_WIDTH-1:0] sensor_c_value,
	input  logic                          sensor_a_ok,
	input  logic                          sensor_b_ok,
	input  logic                          sensor_c_ok,
	input  logic signed [ANGLE_WIDTH-1:0] median_angle,
	input  logic [1:0]                    valid_count,
	output logic signed [ANGLE_WIDTH-1:0] fused_angle,
	output logic signed [ANGLE_WIDTH-1:0] smoothed_angle
);

	localparam int AW      = ANGLE_WIDTH;
	localparam int WGT_W   = iesf_pkg::WGT_W;
	localparam int SUMW_W  = iesf_pkg::SUMW_W;
	localparam int GAIN_W  = iesf_pkg::GAIN_W;
	localparam int VAR_W   = iesf_pkg::VAR_W;
	localparam int ERR_W   = AW + 1;
	localparam int DENW_W  = ((ERR_W > iesf_pkg::EPS_W) ? ERR_W : iesf_pkg::EPS_W) + 1;
	localparam int DEN_W   = (DENW_W > SUMW_W) ? DENW_W : SUMW_W;
	localparam int PROD_W  = AW + WGT_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int QUO_W   = (AW > WGT_W) ? AW : WGT_W;
	localparam int CNT_W   = $clog2(QUO_W + 1);
	localparam int P1_W    = AW + GAIN_W + 2;
	localparam int P2_W    = 2 * VAR_W;

	// captured item
	logic signed [AW-1:0]     x_q [3];
	logic [2:0]               ok_q;
	logic signed [AW-1:0]     med_q;
	logic                     fuse_en_q;

	// weight loop
	logic [ERR_W-1:0]         err_q;
	logic                     den_zero_q;
	logic [WGT_W-1:0]         w_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [SUMW_W-1:0]        sum_w_q;
	logic signed [ACC_W-1:0]  sum_wx_q;
	logic                     neg_q;
	logic signed [AW-1:0]     fused_q;

	// smoother
	logic [GAIN_W-1:0]        gain_q;
	logic signed [AW:0]       diff_q;
	logic signed [P1_W-1:0]   p1_q;
	logic [P2_W-1:0]          p2_q;
	logic signed [AW-1:0]     est_q;
	logic [VAR_W-1:0]         var_q;

	logic signed [AW-1:0]     out_fused_q;
	logic signed [AW-1:0]     out_smooth_q;

	logic signed [AW-1:0]     x_sel;
	logic                     ok_sel;
	logic signed [AW:0]       d;
	logic [ERR_W-1:0]         err_abs;
	logic [DEN_W-1:0]         den_w;
	logic [ACC_W-1:0]         mag;
	logic [WGT_W-1:0]         w;
	logic signed [PROD_W:0]   prod_full;
	logic [GAIN_W-1:0]        gain_sel;
	logic [GAIN_W-1:0]        one_minus;
	logic signed [P1_W-1:0]   p1_full;
	logic signed [AW+2:0]     step;
	logic [AW-1:0]            q_mag;

	logic                     div_start;
	logic [CNT_W-1:0]         div_steps;
	logic [DEN_W-1:0]         div_rem_init;
	logic [QUO_W-1:0]         div_quo_init;
	logic [DEN_W-1:0]         div_den;
	logic                     div_done;
	logic [QUO_W-1:0]         div_quo;

	always_comb begin
		case (cmd.idx)
			2'd1: begin
				x_sel  = x_q[1];
				ok_sel = ok_q[1];
			end
			2'd2: begin
				x_sel  = x_q[2];
				ok_sel = ok_q[2];
			end
			default: begin
				x_sel  = x_q[0];
				ok_sel = ok_q[0];
			end
		endcase
	end

	// |x - median| needs one bit more than the angle
	assign d       = {x_sel[AW-1], x_sel} - {med_q[AW-1], med_q};
	assign err_abs = d[AW] ? ERR_W'(-d) : ERR_W'(d);
	assign den_w   = DEN_W'(err_q) + DEN_W'(cfg.epsilon);

	assign mag = sum_wx_q[ACC_W-1] ? ACC_W'(-sum_wx_q) : ACC_W'(sum_wx_q);

	// divider operand select: mean division when fstart, else weight
	assign div_start = cmd.wstart || cmd.fstart;
	always_comb begin
		if (cmd.fstart) begin
			div_steps    = CNT_W'(AW);
			div_rem_init = DEN_W'(mag[ACC_W-1:AW]);
			div_quo_init = QUO_W'(mag[AW-1:0]) << (QUO_W - AW);
			div_den      = DEN_W'(sum_w_q);
		end else begin
			div_steps    = CNT_W'(WGT_W);
			div_rem_init = '0;
			div_quo_init = QUO_W'(1) << (QUO_W - 1);
			div_den      = den_w;
		end
	end

	iesf_div #(
		.DEN_W (DEN_W),
		.QUO_W (QUO_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.rem_init (div_rem_init),
		.quo_init (div_quo_init),
		.den      (div_den),
		.done     (div_done),
		.quo      (div_quo)
	);

	assign w         = den_zero_q ? iesf_pkg::WEIGHT_NUM : div_quo[WGT_W-1:0];
	assign prod_full = $signed({1'b0, w}) * x_sel;
	assign q_mag     = div_quo[AW-1:0];

	assign gain_sel  = (var_q > cfg.var_thresh) ? cfg.gain_high : cfg.gain_low;
	assign one_minus = iesf_pkg::ONE_Q16 - gain_q;
	assign p1_full   = $signed({1'b0, gain_q}) * diff_q;
	// top bits of the product give floor division by 2^16
	assign step      = p1_q[P1_W-1:GAIN_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			var_q <= iesf_pkg::RST_VARIANCE;
		end else if (cmd.supd) begin
			est_q <= est_q + step[AW-1:0];
			var_q <= p2_q[VAR_W+15:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q[0]    <= sensor_a_value;
			x_q[1]    <= sensor_b_value;
			x_q[2]    <= sensor_c_value;
			ok_q      <= {sensor_c_ok, sensor_b_ok, sensor_a_ok};
			med_q     <= median_angle;
			fuse_en_q <= (valid_count != 2'd0) && (sensor_a_ok || sensor_b_ok || sensor_c_ok);
			sum_w_q   <= '0;
			sum_wx_q  <= '0;
		end
		if (cmd.err)
			err_q <= err_abs;
		if (cmd.wstart)
			den_zero_q <= (den_w == '0);
		if (cmd.wmul) begin
			w_q    <= w;
			prod_q <= prod_full[PROD_W-1:0];
		end
		if (cmd.wacc) begin
			sum_w_q  <= sum_w_q + SUMW_W'(w_q);
			sum_wx_q <= sum_wx_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
		end
		if (cmd.fstart)
			neg_q <= sum_wx_q[ACC_W-1];
		if (cmd.fzero)
			fused_q <= '0;
		else if (cmd.fsign)
			fused_q <= neg_q ? $signed(-q_mag) : $signed(q_mag);
		if (cmd.sgain) begin
			gain_q <= (gain_sel > iesf_pkg::ONE_Q16) ? iesf_pkg::ONE_Q16 : gain_sel;
			diff_q <= {fused_q[AW-1], fused_q} - {est_q[AW-1], est_q};
		end
		if (cmd.smul) begin
			p1_q <= p1_full;
			p2_q <= var_q * one_minus;
		end
		if (cmd.oload) begin
			out_fused_q  <= fused_q;
			out_smooth_q <= est_q;
		end
	end

	assign sts.fuse_en   = fuse_en_q;
	assign sts.sel_ok    = ok_sel;
	assign sts.div_done  = div_done;
	assign sts.sumw_zero = (sum_w_q == '0);

	assign fused_angle    = out_fused_q;
	assign smoothed_angle = out_smooth_q;

endmodule

// ===== src/iesf_ctrl.sv =====
// ----------------------------------------------------------------------------
// iesf_ctrl
// sequencer: walks the three sensors, the mean division and the smoother
// update, and owns the input and output handshakes
// ----------------------------------------------------------------------------
module iesf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  iesf_pkg::sts_t sts,
	output iesf_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_W_CHK,
		ST_W_ERR,
		ST_W_START,
		ST_W_DIV,
		ST_W_MUL,
		ST_W_ACC,
		ST_F_START,
		ST_F_DIV,
		ST_F_SIGN,
		ST_S_GAIN,
		ST_S_MUL,
		ST_S_UPD,
		ST_S_OUT
	} state_t;

	localparam logic [1:0] LAST_IDX = 2'd2;

	state_t     state_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= ST_W_CHK;
					end
				end
				ST_W_CHK: begin
					if (!sts.fuse_en)
						state_q <= ST_F_START;
					else if (sts.sel_ok)
						state_q <= ST_W_ERR;
					else if (idx_q == LAST_IDX)
						state_q <= ST_F_START;
					else
						idx_q <= idx_q + 2'd1;
				end
				ST_W_ERR:   state_q <= ST_W_START;
				ST_W_START: state_q <= ST_W_DIV;
				ST_W_DIV: begin
					if (sts.div_done)
						state_q <= ST_W_MUL;
				end
				ST_W_MUL:   state_q <= ST_W_ACC;
				ST_W_ACC: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_F_START;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_W_CHK;
					end
				end
				ST_F_START: begin
					if (sts.fuse_en && !sts.sumw_zero)
						state_q <= ST_F_DIV;
					else
						state_q <= ST_S_GAIN;
				end
				ST_F_DIV: begin
					if (sts.div_done)
						state_q <= ST_F_SIGN;
				end
				ST_F_SIGN:  state_q <= ST_S_GAIN;
				ST_S_GAIN:  state_q <= ST_S_MUL;
				ST_S_MUL:   state_q <= ST_S_UPD;
				ST_S_UPD:   state_q <= ST_S_OUT;
				ST_S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.idx = idx_q;
		unique case (state_q)
			ST_IDLE:    cmd.load   = in_valid;
			ST_W_ERR:   cmd.err    = 1'b1;
			ST_W_START: cmd.wstart = 1'b1;
			ST_W_MUL:   cmd.wmul   = 1'b1;
			ST_W_ACC:   cmd.wacc   = 1'b1;
			ST_F_START: begin
				cmd.fstart = sts.fuse_en && !sts.sumw_zero;
				cmd.fzero  = !(sts.fuse_en && !sts.sumw_zero);
			end
			ST_F_SIGN:  cmd.fsign  = 1'b1;
			ST_S_GAIN:  cmd.sgain  = 1'b1;
			ST_S_MUL:   cmd.smul   = 1'b1;
			ST_S_UPD:   cmd.supd   = 1'b1;
			ST_S_OUT:   cmd.oload  = out_free;
			default:    cmd.load   = 1'b0;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/inverse_error_sensor_fusion_smoother_top.sv =====
// ----------------------------------------------------------------------------
// inverse_error_sensor_fusion_smoother_top
// inverse-error weighted fusion of three angle readings and a gain-switched
// one-state smoother, one result transfer per input transfer
// ----------------------------------------------------------------------------
// sequence: for each valid reading the error, a bit-serial weight division,
//   a multiply and an accumulate, while an invalid reading is skipped; then,
//   if any weight was summed, the mean division, and the smoother update
// throughput: one item at a time; the shared divider and the sequencer set
//   the rate, and a new item is taken while a finished result still waits
// reset: arst_n clears the sequencer, sets estimate to zero, variance to one
//   and the four registers to their defaults
module inverse_error_sensor_fusion_smoother_top #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,

	// apb configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [iesf_pkg::PADDR_W-1:0] paddr,
	input  logic [iesf_pkg::PDATA_W-1:0] pwdata,
	output logic [iesf_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,

	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ANGLE_WIDTH-1:0] sensor_a_value,
	input  logic signed [ANGLE_WIDTH-1:0] sensor_b_value,
	input  logic signed [ANGLE_WIDTH-1:0] sensor_c_value,
	input  logic                          sensor_a_ok,
	input  logic                          sensor_b_ok,
	input  logic                          sensor_c_ok,
	input  logic signed [ANGLE_WIDTH-1:0] median_angle,
	input  logic [1:0]                    valid_count,

	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ANGLE_WIDTH-1:0] fused_angle,
	output logic signed [ANGLE_WIDTH-1:0] smoothed_angle
);

	iesf_pkg::cfg_t cfg;
	iesf_pkg::cmd_t cmd;
	iesf_pkg::sts_t sts;

	// register writes never stall
	assign pready = 1'b1;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	iesf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer: accepts a transfer in idle, steps through the three
	// weights, the mean division and the smoother, then hands the result
	// to the output register as soon as it is free
	iesf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic: shared restoring divider, the weight and smoother multipliers
	// and the output register that decouples the two channels
	iesf_dp #(
		.ANGLE_WIDTH (ANGLE_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg            (cfg),
		.sensor_a_value (sensor_a_value),
		.sensor_b_value (sensor_b_value),
		.sensor_c_value (sensor_c_value),
		.sensor_a_ok    (sensor_a_ok),
		.sensor_b_ok    (sensor_b_ok),
		.sensor_c_ok    (sensor_c_ok),
		.median_angle   (median_angle),
		.valid_count    (valid_count),
		.fused_angle    (fused_angle),
		.smoothed_angle (smoothed_angle)
	);

endmodule

// ===== src/iesf_check.sv =====
// ----------------------------------------------------------------------------
// iesf_check
// port-level checks for the fusion smoother, bound to the top level
// ----------------------------------------------------------------------------
module iesf_check #(
	parameter int ANGLE_WIDTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          pwrite,
	input logic [iesf_pkg::PADDR_W-1:0]  paddr,
	input logic [iesf_pkg::PDATA_W-1:0]  prdata,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [ANGLE_WIDTH-1:0] fused_angle,
	input logic signed [ANGLE_WIDTH-1:0] smoothed_angle
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fused_angle)
			&& $stable(smoothed_angle))
		else $error("result changed while stalled");

	// an accepted item keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// a new result appears only as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while busy");

	// register reads return only the implemented bits
	a_read_width: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> prdata[iesf_pkg::PDATA_W-1:iesf_pkg::CFG_W] == '0
			&& (paddr[iesf_pkg::PADDR_W-1:2] != 2'd0
				|| prdata[iesf_pkg::CFG_W-1:iesf_pkg::EPS_W] == '0))
		else $error("register read has stray upper bits");

	// reset held across an edge leaves the block empty and ready
	a_reset_state: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> !out_valid && in_ready)
		else $error("block not idle in reset");

endmodule

bind inverse_error_sensor_fusion_smoother_top iesf_check #(
	.ANGLE_WIDTH (ANGLE_WIDTH)
) u_iesf_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.psel           (psel),
	.pwrite         (pwrite),
	.paddr          (paddr),
	.prdata         (prdata),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.fused_angle    (fused_angle),
	.smoothed_angle (smoothed_angle)
);

// ===== test/inverse_error_sensor_fusion_smoother_top_tb.sv =====
// ----------------------------------------------------------------------------
// inverse_error_sensor_fusion_smoother_top_tb
// self-checking bench for the fusion smoother: a behavioral predictor tracks
// estimate, variance and the four registers, computes the fused and smoothed
// angle of every accepted input transfer, and each output transfer is matched
// in order against it; directed corner items come first, then random phases
// with changing register settings and random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inverse_error_sensor_fusion_smoother_top_tb;

	localparam int ANGLE_W = 16;

	// predictor constants, widened to 64 bit signed
	localparam longint WEIGHT_FULL = longint'(iesf_pkg::WEIGHT_NUM);
	localparam longint GAIN_ONE    = longint'(iesf_pkg::ONE_Q16);

	typedef struct {
		logic signed [ANGLE_W-1:0] a_val;
		logic signed [ANGLE_W-1:0] b_val;
		logic signed [ANGLE_W-1:0] c_val;
		logic [2:0]                ok;     // bit 0 sensor a, bit 1 b, bit 2 c
		logic signed [ANGLE_W-1:0] median;
		logic [1:0]                count;
	} sensor_set_t;

	typedef struct {
		logic signed [ANGLE_W-1:0] fused;
		logic signed [ANGLE_W-1:0] smoothed;
	} fusion_result_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// block ports, all driven to known values from time zero
	logic                            psel    = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite  = 1'b0;
	logic [iesf_pkg::PADDR_W-1:0]    paddr   = '0;
	logic [iesf_pkg::PDATA_W-1:0]    pwdata  = '0;
	logic [iesf_pkg::PDATA_W-1:0]    prdata;
	logic                            pready;
	logic                            in_valid       = 1'b0;
	logic                            in_ready;
	logic signed [ANGLE_W-1:0]       sensor_a_value = '0;
	logic signed [ANGLE_W-1:0]       sensor_b_value = '0;
	logic signed [ANGLE_W-1:0]       sensor_c_value = '0;
	logic                            sensor_a_ok    = 1'b0;
	logic                            sensor_b_ok    = 1'b0;
	logic                            sensor_c_ok    = 1'b0;
	logic signed [ANGLE_W-1:0]       median_angle   = '0;
	logic [1:0]                      valid_count    = '0;
	logic                            out_valid;
	logic                            out_ready      = 1'b0;
	logic signed [ANGLE_W-1:0]       fused_angle;
	logic signed [ANGLE_W-1:0]       smoothed_angle;

	inverse_error_sensor_fusion_smoother_top #(
		.ANGLE_WIDTH(ANGLE_W)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sensor_a_value(sensor_a_value),
		.sensor_b_value(sensor_b_value),
		.sensor_c_value(sensor_c_value),
		.sensor_a_ok   (sensor_a_ok),
		.sensor_b_ok   (sensor_b_ok),
		.sensor_c_ok   (sensor_c_ok),
		.median_angle  (median_angle),
		.valid_count   (valid_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fused_angle   (fused_angle),
		.smoothed_angle(smoothed_angle)
	);

	// predictor copy of the registers and the smoother state
	longint fuse_eps    = longint'(iesf_pkg::RST_EPSILON);
	longint fuse_thresh = longint'(iesf_pkg::RST_VAR_THRESH);
	longint gain_hi     = longint'(iesf_pkg::RST_GAIN_HIGH);
	longint gain_lo     = longint'(iesf_pkg::RST_GAIN_LOW);
	longint est_q       = 0;
	longint var_q       = longint'(iesf_pkg::RST_VARIANCE);

	fusion_result_t pending_results[$];
	int             mismatches = 0;

	// idling controls, both cleared for the closing stream
	bit send_gaps = 1'b1;
	bit stall_en  = 1'b1;
	int stall_left = 0;

	// weighted mean of the valid readings, then one smoother update
	function automatic void predict_result(input sensor_set_t s, output fusion_result_t r);
		longint x[3];
		longint den, w, sum_w, sum_wx, fused, gain;
		x[0]   = longint'(s.a_val);
		x[1]   = longint'(s.b_val);
		x[2]   = longint'(s.c_val);
		sum_w  = 0;
		sum_wx = 0;
		fused  = 0;
		// flags alone pick the readings; a zero count or no flag gives zero
		if (s.count != 0 && s.ok != 0) begin
			for (int i = 0; i < 3; i++) begin
				if (s.ok[i]) begin
					den = x[i] - longint'(s.median);
					if (den < 0)
						den = -den;
					den = den + fuse_eps;
					// zero divisor saturates the weight
					w = (den == 0) ? WEIGHT_FULL : WEIGHT_FULL / den;
					sum_w  = sum_w + w;
					sum_wx = sum_wx + w * x[i];
				end
			end
			// signed division truncates toward zero
			if (sum_w > 0)
				fused = sum_wx / sum_w;
		end
		gain = (var_q > fuse_thresh) ? gain_hi : gain_lo;
		if (gain > GAIN_ONE)
			gain = GAIN_ONE;
		// arithmetic shift is the floor of the q1.16 product
		est_q = est_q + ((gain * (fused - est_q)) >>> 16);
		var_q = ((var_q * (GAIN_ONE - gain)) >>> 16) & 64'h1FFFF;
		r.fused    = fused[ANGLE_W-1:0];
		r.smoothed = est_q[ANGLE_W-1:0];
	endfunction

	function automatic sensor_set_t mk_set(int a, int b, int c, logic [2:0] ok, int med,
			logic [1:0] cnt);
		sensor_set_t s;
		s.a_val  = ANGLE_W'(a);
		s.b_val  = ANGLE_W'(b);
		s.c_val  = ANGLE_W'(c);
		s.ok     = ok;
		s.median = ANGLE_W'(med);
		s.count  = cnt;
		return s;
	endfunction

	// mostly clustered readings with a consistent median and count,
	// the rest fully random noise
	function automatic sensor_set_t random_set();
		sensor_set_t s;
		int v[3];
		int picked[$];
		int base;
		int spread;
		if ($urandom_range(9, 0) < 3) begin
			s.a_val  = ANGLE_W'($urandom);
			s.b_val  = ANGLE_W'($urandom);
			s.c_val  = ANGLE_W'($urandom);
			s.ok     = 3'($urandom);
			s.median = ANGLE_W'($urandom);
			s.count  = 2'($urandom);
		end else begin
			base   = int'($urandom_range(65535, 0)) - 32768;
			spread = 1 << $urandom_range(15, 0);
			for (int i = 0; i < 3; i++) begin
				v[i] = base + int'($urandom_range(2 * spread, 0)) - spread;
				if (v[i] > 32767)
					v[i] = 32767;
				if (v[i] < -32768)
					v[i] = -32768;
			end
			s.a_val = ANGLE_W'(v[0]);
			s.b_val = ANGLE_W'(v[1]);
			s.c_val = ANGLE_W'(v[2]);
			s.ok    = $urandom_range(1, 0) ? 3'b111 : 3'($urandom);
			for (int i = 0; i < 3; i++)
				if (s.ok[i])
					picked.push_back(v[i]);
			picked.sort();
			s.median = ANGLE_W'((picked.size() == 0) ? base : picked[picked.size() / 2]);
			s.count  = 2'($countones(s.ok));
			// occasional count that disagrees with the flags
			if ($urandom_range(7, 0) == 0)
				s.count = 2'($urandom);
		end
		return s;
	endfunction

	// one input transfer; valid stays high across back-to-back items
	task automatic send_set(input sensor_set_t s);
		fusion_result_t want;
		if (send_gaps && $urandom_range(3, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		sensor_a_value <= s.a_val;
		sensor_b_value <= s.b_val;
		sensor_c_value <= s.c_val;
		sensor_a_ok    <= s.ok[0];
		sensor_b_ok    <= s.ok[1];
		sensor_c_ok    <= s.ok[2];
		median_angle   <= s.median;
		valid_count    <= s.count;
		in_valid       <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predict_result(s, want);
		pending_results.push_back(want);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// apb write: setup cycle, access cycle, register taken when pready is high
	task automatic write_register(input iesf_pkg::reg_idx_t idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		unique case (idx)
			iesf_pkg::REG_EPSILON:    fuse_eps    = longint'(value & 32'hFFFF);
			iesf_pkg::REG_VAR_THRESH: fuse_thresh = longint'(value & 32'h1FFFF);
			iesf_pkg::REG_GAIN_HIGH:  gain_hi     = longint'(value & 32'h1FFFF);
			iesf_pkg::REG_GAIN_LOW:   gain_lo     = longint'(value & 32'h1FFFF);
		endcase
		// keeps psel from being lowered and raised in one step
		@(posedge clk);
	endtask

	task automatic apply_settings(input int unsigned eps, input int unsigned thresh,
			input int unsigned g_high, input int unsigned g_low);
		write_register(iesf_pkg::REG_EPSILON, eps);
		write_register(iesf_pkg::REG_VAR_THRESH, thresh);
		write_register(iesf_pkg::REG_GAIN_HIGH, g_high);
		write_register(iesf_pkg::REG_GAIN_LOW, g_low);
	endtask

	function automatic int unsigned pick_gain();
		case ($urandom_range(4, 0))
			0:       return 0;
			1:       return 65536;
			2:       return 131071;
			3:       return 65535;
			default: return $urandom_range(131071, 0);
		endcase
	endfunction

	// register defaults: the first update runs on the two-thirds gain
	task automatic test_reset_config();
		send_set(mk_set(256, 300, 200, 3'b111, 256, 2'd3));
		drain_results();
	endtask

	// full-scale readings, single sensors, empty and inconsistent flag sets;
	// a small high gain keeps the variance above zero for later phases
	task automatic test_field_extremes();
		apply_settings(256, 0, 1024, 0);
		send_set(mk_set(32767, 32767, 32767, 3'b111, 32767, 2'd3));
		send_set(mk_set(-32768, -32768, -32768, 3'b111, -32768, 2'd3));
		send_set(mk_set(32767, -32768, 0, 3'b111, 0, 2'd3));
		send_set(mk_set(-32768, 32767, -1, 3'b111, 32767, 2'd3));
		send_set(mk_set(100, 200, 300, 3'b001, 200, 2'd1));
		send_set(mk_set(100, 200, 300, 3'b010, 200, 2'd1));
		send_set(mk_set(100, 200, 300, 3'b100, 200, 2'd1));
		send_set(mk_set(5, 6, 7, 3'b000, 6, 2'd0));
		send_set(mk_set(5, 6, 7, 3'b111, 6, 2'd0));
		send_set(mk_set(5, 6, 7, 3'b000, 6, 2'd3));
		send_set(mk_set(-500, -400, 900, 3'b011, -450, 2'd3));
		send_set(mk_set(-1, 0, 1, 3'b110, 0, 2'd2));
		drain_results();
	endtask

	// epsilon zero with readings on the median, then epsilon extremes
	task automatic test_zero_epsilon();
		write_register(iesf_pkg::REG_EPSILON, 0);
		send_set(mk_set(1000, 1000, 1000, 3'b111, 1000, 2'd3));
		send_set(mk_set(1000, -3000, 2000, 3'b111, 1000, 2'd3));
		send_set(mk_set(-32768, 32767, 0, 3'b101, -32768, 2'd2));
		drain_results();
		write_register(iesf_pkg::REG_EPSILON, 65535);
		send_set(mk_set(-32768, 32767, 12345, 3'b111, 0, 2'd3));
		send_set(mk_set(32767, 32767, -32768, 3'b111, -32768, 2'd3));
		drain_results();
		write_register(iesf_pkg::REG_EPSILON, 1);
		send_set(mk_set(7, -7, 0, 3'b111, 0, 2'd3));
		drain_results();
	endtask

	// random phases; early ones keep gains small so the variance decays
	// slowly and crosses a threshold picked below it, later ones go wide
	task automatic test_random_phases();
		int unsigned eps;
		int unsigned thresh;
		for (int phase = 0; phase < 14; phase++) begin
			case ($urandom_range(5, 0))
				0:       eps = 0;
				1:       eps = 1;
				2:       eps = 65535;
				default: eps = $urandom_range(65535, 0);
			endcase
			if (var_q > 0 && $urandom_range(1, 0))
				thresh = $urandom_range(int'(var_q), 0);
			else begin
				case ($urandom_range(3, 0))
					0:       thresh = 0;
					1:       thresh = 65536;
					2:       thresh = 131071;
					default: thresh = $urandom_range(131071, 0);
				endcase
			end
			if (phase < 9)
				apply_settings(eps, thresh, $urandom_range(4095, 0), $urandom_range(4095, 0));
			else
				apply_settings(eps, thresh, pick_gain(), pick_gain());
			repeat (100)
				send_set(random_set());
			drain_results();
		end
	endtask

	// gains above one are clamped to one on both branches
	task automatic test_gain_saturation();
		apply_settings(int'(fuse_eps), 0, 131071, 131071);
		repeat (5)
			send_set(random_set());
		drain_results();
		apply_settings(int'(fuse_eps), 131071, 0, 65536);
		repeat (5)
			send_set(random_set());
		drain_results();
	endtask

	// closing stream with no idling on either side
	task automatic test_steady_stream();
		send_gaps = 1'b0;
		stall_en  = 1'b0;
		apply_settings($urandom_range(65535, 1), $urandom_range(131071, 0),
			$urandom_range(65536, 0), $urandom_range(65536, 0));
		repeat (150)
			send_set(random_set());
		drain_results();
	endtask

	// output side: match each result transfer in order, and stall at random
	always @(posedge clk) begin : check_results
		fusion_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: fused %0d smoothed %0d",
						fused_angle, smoothed_angle);
			end else begin
				want = pending_results.pop_front();
				if (fused_angle !== want.fused || smoothed_angle !== want.smoothed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: fused exp %0d got %0d, smoothed exp %0d got %0d",
							want.fused, fused_angle, want.smoothed, smoothed_angle);
				end
			end
		end
		// random stall bursts hold out_ready low
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_en && $urandom_range(4, 0) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(3, 0);
		end else
			out_ready <= 1'b1;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_field_extremes();
		test_zero_epsilon();
		test_random_phases();
		test_gain_saturation();
		test_steady_stream();
		// catch any stray transfer after the last expected one
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#12_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
